// ----- src/emt_pkg.sv -----
// ----------------------------------------------------------------------------
// Encoder multi-turn tracker package
// Types and constants shared by the tracker and its update stage.
// ----------------------------------------------------------------------------
package emt_pkg;

  localparam int unsigned FrameW   = 64;
  localparam int unsigned AngleW   = 16;
  localparam int unsigned FracW    = 18;
  localparam int unsigned TurnW    = 16;
  localparam int unsigned OutW     = 32;
  localparam int unsigned SumW     = 21;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned SlotW    = 3;

  localparam logic [CfgIdxW-1:0] RegEncoderSlot   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegReverseEnable = 2'd1;
  localparam logic [CfgIdxW-1:0] RegReverseSpan   = 2'd2;
  localparam logic [CfgIdxW-1:0] RegAngleMode     = 2'd3;

  localparam logic [SlotW-1:0]  SlotReset = 3'd1;
  localparam logic [AngleW-1:0] SpanReset = 16'd8192;

  localparam logic [1:0] Pair0 = 2'd0;
  localparam logic [1:0] Pair1 = 2'd1;
  localparam logic [1:0] Pair2 = 2'd2;
  localparam logic [1:0] Pair3 = 2'd3;

  typedef struct packed {
    logic [SlotW-1:0]  encoder_slot;
    logic              reverse_enable;
    logic [AngleW-1:0] reverse_span;
    logic              angle_mode;
  } emt_cfg_t;

  typedef struct packed {
    logic              first_pending;
    logic [AngleW-1:0] previous_angle;
    logic [FracW-1:0]  turn_fraction;
    logic [TurnW-1:0]  turn_count;
  } emt_state_t;

  typedef struct packed {
    logic [AngleW-1:0] raw_angle;
    logic [OutW-1:0]   angle_out;
  } emt_result_t;

endpackage

// ----- src/encoder_multiturn_tracker.sv -----
// ----------------------------------------------------------------------------
// Encoder multi-turn tracker
// Unwraps a single-turn encoder angle taken from sensor frames into a
// multi-turn position; with angle_mode clear it outputs the angle itself.
// ----------------------------------------------------------------------------
//  Channel  Direction  Beat contents
//  s_axis   in         frame_payload[63:0]
//  m_axis   out        raw_angle[15:0], angle_out[47:16]
//  cfg      in         register index and 16-bit data, no read-back
//
//  One beat is accepted per cycle unless m_axis stalls; results go through the
//  input and output registers. The unwrap step on the stored angle and turn
//  count sets the single-cycle rate. Reset clears the configuration to its
//  defaults and marks the next frame as the first. A stall on m_axis holds both
//  stages and deasserts s_axis_tready once the input stage is full.
// ----------------------------------------------------------------------------
module encoder_multiturn_tracker #(
  parameter int unsigned COUNTS_PER_TURN = 8192
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // frame_payload[63:0]
  input  logic [63:0]                   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // raw_angle[15:0], angle_out[47:16]
  output logic [47:0]                   m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [emt_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [emt_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  emt_pkg::emt_cfg_t           cfg_q;
  emt_pkg::emt_state_t         st_q, st_d;
  emt_pkg::emt_result_t        res_d, res_q;
  logic                        in_valid_q;
  logic [emt_pkg::FrameW-1:0]  in_data_q;
  logic                        out_valid_q;
  logic                        adv;

  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.encoder_slot   <= emt_pkg::SlotReset;
      cfg_q.reverse_enable <= 1'b0;
      cfg_q.reverse_span   <= emt_pkg::SpanReset;
      cfg_q.angle_mode     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        emt_pkg::RegEncoderSlot:   cfg_q.encoder_slot   <= cfg_wdata_i[emt_pkg::SlotW-1:0];
        emt_pkg::RegReverseEnable: cfg_q.reverse_enable <= cfg_wdata_i[0];
        emt_pkg::RegReverseSpan:   cfg_q.reverse_span   <= cfg_wdata_i[emt_pkg::AngleW-1:0];
        emt_pkg::RegAngleMode:     cfg_q.angle_mode     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data_q <= s_axis_tdata;
    end
  end

  emt_step #(
    .COUNTS_PER_TURN(COUNTS_PER_TURN)
  ) u_step (
    .frame_payload_i(in_data_q),
    .cfg_i          (cfg_q),
    .state_i        (st_q),
    .state_o        (st_d),
    .result_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.first_pending  <= 1'b1;
      st_q.previous_angle <= '0;
      st_q.turn_fraction  <= '0;
      st_q.turn_count     <= '0;
      out_valid_q         <= 1'b0;
    end else begin
      if (adv) begin
        st_q        <= st_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {res_q.angle_out, res_q.raw_angle};

  a_first_clears_turns : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && st_q.first_pending) |=> (!st_q.first_pending && st_q.turn_count == '0))
    else $error("first frame did not clear the turn count");

  a_state_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(st_q))
    else $error("tracker state changed without a beat");

  a_turn_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> (st_q.turn_count == $past(st_q.turn_count)
          || st_q.turn_count == $past(st_q.turn_count) + emt_pkg::TurnW'(1)
          || st_q.turn_count == $past(st_q.turn_count) - emt_pkg::TurnW'(1)
          || st_q.turn_count == '0))
    else $error("turn count moved by more than one turn");

  a_stall_holds_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> (out_valid_q && $stable(res_q)))
    else $error("result changed while stalled");

endmodule

// ----- src/emt_step.sv -----
// ----------------------------------------------------------------------------
// Encoder multi-turn tracker update stage
// Picks and optionally reverses the angle, unwraps it against the stored
// state and forms the next state and the result of one beat.
// ----------------------------------------------------------------------------
module emt_step #(
  parameter int unsigned COUNTS_PER_TURN = 8192
) (
  input  logic [emt_pkg::FrameW-1:0] frame_payload_i,
  input  emt_pkg::emt_cfg_t          cfg_i,
  input  emt_pkg::emt_state_t        state_i,
  output emt_pkg::emt_state_t        state_o,
  output emt_pkg::emt_result_t       result_o
);

  localparam logic signed [emt_pkg::SumW-1:0] CptS = emt_pkg::SumW'(COUNTS_PER_TURN);
  localparam logic signed [emt_pkg::OutW-1:0] CptW = emt_pkg::OutW'(COUNTS_PER_TURN);

  logic [1:0]                        pair;
  logic [emt_pkg::AngleW-1:0]        raw;
  logic [emt_pkg::AngleW-1:0]        angle;
  logic signed [emt_pkg::SumW-1:0]   delta;
  logic signed [emt_pkg::SumW-1:0]   delta_c;
  logic signed [emt_pkg::SumW-1:0]   delta_2;
  logic signed [emt_pkg::SumW-1:0]   sum;
  logic signed [emt_pkg::SumW-1:0]   sum_c;
  logic [emt_pkg::TurnW-1:0]         turns;
  logic signed [emt_pkg::OutW-1:0]   turn_ext;
  logic signed [emt_pkg::OutW-1:0]   multi;

  assign pair = 2'(cfg_i.encoder_slot - emt_pkg::SlotW'(1));

  always_comb begin
    case (pair)
      emt_pkg::Pair0: raw = frame_payload_i[15:0];
      emt_pkg::Pair1: raw = frame_payload_i[31:16];
      emt_pkg::Pair2: raw = frame_payload_i[47:32];
      emt_pkg::Pair3: raw = frame_payload_i[63:48];
      default:        raw = frame_payload_i[15:0];
    endcase
  end

  assign angle = cfg_i.reverse_enable ? cfg_i.reverse_span - raw : raw;

  assign delta   = emt_pkg::SumW'({1'b0, angle}) - emt_pkg::SumW'({1'b0, state_i.previous_angle});
  assign delta_2 = delta <<< 1;

  always_comb begin
    delta_c = delta;
    if (delta >= 0) begin
      if (delta_2 > CptS) begin
        delta_c = delta - CptS;
      end
    end else begin
      if (delta_2 <= -CptS) begin
        delta_c = delta + CptS;
      end
    end
  end

  assign sum = delta_c + emt_pkg::SumW'({1'b0, state_i.turn_fraction});

  always_comb begin
    sum_c = sum;
    turns = state_i.turn_count;
    if (sum > CptS) begin
      sum_c = sum - CptS;
      turns = state_i.turn_count + emt_pkg::TurnW'(1);
    end else if (sum < 0) begin
      sum_c = sum + CptS;
      turns = state_i.turn_count - emt_pkg::TurnW'(1);
    end
  end

  always_comb begin
    state_o                = state_i;
    state_o.first_pending  = 1'b0;
    state_o.previous_angle = angle;
    if (state_i.first_pending) begin
      state_o.turn_count = '0;
    end else begin
      state_o.turn_fraction = sum_c[emt_pkg::FracW-1:0];
      state_o.turn_count    = turns;
    end
  end

  assign turn_ext = emt_pkg::OutW'(signed'(state_o.turn_count));
  assign multi    = emt_pkg::OutW'({1'b0, state_o.turn_fraction}) + turn_ext * CptW;

  assign result_o.raw_angle = angle;
  assign result_o.angle_out = cfg_i.angle_mode ? multi : emt_pkg::OutW'(angle);

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// Encoder multi-turn tracker testbench
// Sends sensor frames through the stream input and predicts each result from
// a behavioural copy of the unwrap state. Covers the default registers, slot
// selection, direction reversal, half-turn and wrap boundaries, a long output
// stall and large jumps past one turn, then random traffic in several settings.
// ----------------------------------------------------------------------------
module tb;

  localparam longint CountsPerTurn = 8192;
  localparam int     HoldOffCycles = 300;

  typedef enum int {RxAlways, RxChoppy, RxMostly, RxPattern} rx_mode_e;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  logic [63:0]                  s_axis_tdata;   // frame_payload[63:0]
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  logic [47:0]                  m_axis_tdata;   // raw_angle[15:0], angle_out[47:16]
  logic                         cfg_we_i;
  logic [emt_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [emt_pkg::CfgDataW-1:0] cfg_wdata_i;

  emt_pkg::emt_cfg_t    cfg_model;
  emt_pkg::emt_state_t  track;
  emt_pkg::emt_result_t pending_positions[$];

  int unsigned mismatches = 0;
  int          hold_cycles = 0;
  int          burst_left = 0;
  int          rx_phase = 0;
  int          walk_pos = 0;
  bit          steady_tx = 1'b0;
  rx_mode_e    rx_mode = RxAlways;

  encoder_multiturn_tracker #(
    .COUNTS_PER_TURN(32'(CountsPerTurn))
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("** encoder_multiturn_tracker: FAILED **");
    $finish;
  end

  function automatic emt_pkg::emt_result_t unwrap_frame(input logic [63:0] frame);
    logic [1:0]                 pair;
    logic [emt_pkg::AngleW-1:0] angle;
    longint                     step;
    longint                     sum;
    longint                     turns;
    emt_pkg::emt_result_t       res;
    pair  = 2'(cfg_model.encoder_slot - 3'd1);
    angle = frame[16*pair +: 16];
    if (cfg_model.reverse_enable) begin
      angle = cfg_model.reverse_span - angle;
    end
    if (track.first_pending) begin
      track.first_pending = 1'b0;
      track.turn_count    = '0;
    end else begin
      step = longint'(angle) - longint'(track.previous_angle);
      if (step >= 0 && 2 * step > CountsPerTurn) begin
        step -= CountsPerTurn;
      end else if (step < 0 && 2 * step <= -CountsPerTurn) begin
        step += CountsPerTurn;
      end
      sum   = step + longint'(track.turn_fraction);
      turns = longint'($signed(track.turn_count));
      if (sum > CountsPerTurn) begin
        sum   -= CountsPerTurn;
        turns += 1;
      end else if (sum < 0) begin
        sum   += CountsPerTurn;
        turns -= 1;
      end
      track.turn_fraction = sum[emt_pkg::FracW-1:0];
      track.turn_count    = turns[emt_pkg::TurnW-1:0];
    end
    track.previous_angle = angle;
    res.raw_angle = angle;
    if (cfg_model.angle_mode) begin
      sum = longint'(track.turn_fraction) +
            longint'($signed(track.turn_count)) * CountsPerTurn;
      res.angle_out = sum[emt_pkg::OutW-1:0];
    end else begin
      res.angle_out = {16'd0, angle};
    end
    return res;
  endfunction

  function automatic logic [63:0] frame_with_angle(input logic [emt_pkg::AngleW-1:0] angle);
    logic [63:0] frame;
    logic [1:0]  pair;
    frame = {$urandom, $urandom};
    pair  = 2'(cfg_model.encoder_slot - 3'd1);
    frame[16*pair +: 16] = angle;
    return frame;
  endfunction

  // Mostly a plausible encoder walking within one turn, sometimes pure noise.
  function automatic logic [63:0] next_frame();
    int step;
    if ($urandom_range(0, 3) == 0) begin
      return {$urandom, $urandom};
    end
    case ($urandom_range(0, 9))
      0: begin
        step = 4096;
      end
      1: begin
        step = -4096;
      end
      default: begin
        step = int'($urandom_range(0, 8192)) - 4096;
      end
    endcase
    walk_pos = (walk_pos + step) & 8191;
    return frame_with_angle(16'(walk_pos));
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < 50) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
    mismatches++;
  endtask

  task automatic send_frame(input logic [63:0] frame);
    int gap;
    if (!steady_tx && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= frame;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_positions.push_back(unwrap_frame(frame));
    if (burst_left > 0) begin
      burst_left--;
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_positions.size() != 0);
  endtask

  task automatic write_reg(input logic [emt_pkg::CfgIdxW-1:0] idx,
                           input logic [emt_pkg::CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      emt_pkg::RegEncoderSlot: begin
        cfg_model.encoder_slot = data[emt_pkg::SlotW-1:0];
      end
      emt_pkg::RegReverseEnable: begin
        cfg_model.reverse_enable = data[0];
      end
      emt_pkg::RegReverseSpan: begin
        cfg_model.reverse_span = data;
      end
      default: begin
        cfg_model.angle_mode = data[0];
      end
    endcase
  endtask

  // The output stall pattern; a hold-off, when requested, takes precedence.
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_mode)
          RxAlways: begin
            m_axis_tready <= 1'b1;
          end
          RxChoppy: begin
            m_axis_tready <= ($urandom_range(0, 1) == 1);
          end
          RxMostly: begin
            m_axis_tready <= ($urandom_range(0, 7) != 0);
          end
          default: begin
            rx_phase = (rx_phase + 1) % 7;
            m_axis_tready <= (rx_phase < 4);
          end
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    emt_pkg::emt_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_positions.size() == 0) begin
        report_mismatch($sformatf("unexpected beat %h", m_axis_tdata));
      end else begin
        want = pending_positions.pop_front();
        if (m_axis_tdata[15:0] !== want.raw_angle) begin
          report_mismatch($sformatf("raw_angle %0d, expected %0d",
                                    m_axis_tdata[15:0], want.raw_angle));
        end
        if (m_axis_tdata[47:16] !== want.angle_out) begin
          report_mismatch($sformatf("angle_out %0d, expected %0d",
                                    $signed(m_axis_tdata[47:16]), $signed(want.angle_out)));
        end
      end
    end
  end

  task automatic test_tracking_from_reset();
    logic [15:0] angles [10] = '{16'd12288, 16'd8192, 16'd12289, 16'd4096, 16'd0,
                                 16'd4095, 16'd8190, 16'd4095, 16'd0, 16'd61440};
    send_frame('0);
    send_frame(frame_with_angle(16'd4096));
    send_frame(frame_with_angle(16'd8192));
    wait_drained();
    write_reg(emt_pkg::RegAngleMode, 16'd1);
    foreach (angles[i]) begin
      send_frame(frame_with_angle(angles[i]));
    end
    send_frame('1);
    send_frame('0);
    wait_drained();
  endtask

  task automatic test_slot_select();
    for (int slot = 0; slot < 8; slot++) begin
      wait_drained();
      write_reg(emt_pkg::RegEncoderSlot, {13'($urandom), 3'(slot)});
      send_frame({$urandom, $urandom});
    end
    wait_drained();
  endtask

  task automatic test_reverse();
    write_reg(emt_pkg::RegReverseEnable, 16'd1);
    send_frame(frame_with_angle(16'd0));
    send_frame(frame_with_angle(16'd8193));
    wait_drained();
    write_reg(emt_pkg::RegReverseSpan, 16'd0);
    send_frame(frame_with_angle(16'd1));
    wait_drained();
    write_reg(emt_pkg::RegReverseSpan, 16'hFFFF);
    send_frame(frame_with_angle(16'hFFFF));
    send_frame(frame_with_angle(16'd0));
    wait_drained();
  endtask

  task automatic test_output_stall();
    rx_mode   = RxAlways;
    steady_tx = 1'b1;
    hold_cycles = HoldOffCycles;
    repeat (48) send_frame(next_frame());
    wait_drained();
  endtask

  // Descents by exactly half a turn with one large rise per sweep push the
  // fraction well past one turn, so the count steps up on almost every frame.
  task automatic test_large_jumps();
    write_reg(emt_pkg::RegEncoderSlot, 16'd2);
    write_reg(emt_pkg::RegReverseEnable, 16'd0);
    write_reg(emt_pkg::RegAngleMode, 16'd1);
    rx_mode   = RxAlways;
    steady_tx = 1'b1;
    repeat (4) begin
      for (int k = 0; k < 16; k++) begin
        send_frame(frame_with_angle(16'((k == 0) ? 0 : 65536 - 4096 * k)));
      end
    end
    wait_drained();
  endtask

  task automatic test_random_traffic();
    logic [15:0] span;
    logic        reverse;
    logic        mode;
    for (int phase = 0; phase < 8; phase++) begin
      wait_drained();
      case (phase)
        0: begin
          span = 16'd0;
        end
        1: begin
          span = 16'hFFFF;
        end
        2: begin
          span = emt_pkg::SpanReset;
        end
        default: begin
          span = 16'($urandom);
        end
      endcase
      reverse = (phase < 2) ? 1'b1 : 1'($urandom_range(0, 1));
      mode    = (phase < 4) ? 1'(phase % 2) : 1'($urandom_range(0, 1));
      write_reg(emt_pkg::RegEncoderSlot, 16'($urandom));
      write_reg(emt_pkg::RegReverseEnable, {15'($urandom), reverse});
      write_reg(emt_pkg::RegReverseSpan, span);
      write_reg(emt_pkg::RegAngleMode, {15'($urandom), mode});
      rx_mode   = rx_mode_e'($urandom_range(0, 3));
      steady_tx = ($urandom_range(0, 3) == 0);
      repeat (190) send_frame(next_frame());
    end
    wait_drained();
  endtask

  initial begin
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= '0;
    cfg_wdata_i   <= '0;
    rst_ni        <= 1'b0;
    cfg_model = '{encoder_slot: emt_pkg::SlotReset, reverse_enable: 1'b0,
                  reverse_span: emt_pkg::SpanReset, angle_mode: 1'b0};
    track     = '{first_pending: 1'b1, default: '0};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_tracking_from_reset();
    test_slot_select();
    test_reverse();
    test_output_stall();
    test_large_jumps();
    test_random_traffic();

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** encoder_multiturn_tracker: PASSED **");
    end else begin
      $display("** encoder_multiturn_tracker: FAILED **");
    end
    $finish;
  end

endmodule

// ----- encoder_multiturn_tracker.f -----
src/emt_pkg.sv
src/emt_step.sv
src/encoder_multiturn_tracker.sv
test/tb.sv
